// ----- rtl/core/bpa_pkg.sv -----
package bpa_pkg;

  // default sizing
  localparam int NUM_PAGES_DEF  = 4096;
  localparam int NUM_ORDERS_DEF = 11;
  localparam int PAGE_COUNT_RST = 4096;

  // fixed field widths
  localparam int FUNC_W   = 2;
  localparam int ORDER_W  = 4;
  localparam int PAGE_W   = 12;
  localparam int STATUS_W = 2;
  localparam int TOTAL_W  = 13;
  localparam int CFG_W    = 13;
  localparam int IN_W     = 24;
  localparam int OUT_W    = 32;
  // scratch width for page arithmetic over the whole parameter range
  localparam int XW       = 17;

  localparam logic [ORDER_W-1:0] TAG_INUSE = 4'd15;

  // operation codes
  localparam logic [FUNC_W-1:0] FN_ALLOC = 2'd0;
  localparam logic [FUNC_W-1:0] FN_FREE  = 2'd1;
  localparam logic [FUNC_W-1:0] FN_INIT  = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] STS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STS_NO_BLOCK  = 2'd1;
  localparam logic [STATUS_W-1:0] STS_BAD_ORDER = 2'd2;
  localparam logic [STATUS_W-1:0] STS_BAD_PAGE  = 2'd3;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_BAD_ORDER,
    OP_NO_BLOCK,
    OP_BAD_PAGE,
    OP_ALLOC_TAKE,
    OP_RD_TAG_PG,
    OP_FREE_GO,
    OP_RD_TAG_BUD,
    OP_RD_LINKS,
    OP_UNLINK1,
    OP_UNLINK2,
    OP_MERGE,
    OP_DEC_ORD,
    OP_ALLOC_FIN,
    OP_PUSH_A_IDX,
    OP_PUSH_A_SPLIT,
    OP_PUSH_B,
    OP_CLEAR,
    OP_SWEEP,
    OP_INIT_PAGE,
    OP_EMIT
  } op_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISPATCH,
    S_BADORD,
    S_A_FIND,
    S_A_SPLIT,
    S_F_RD,
    S_F_CHK,
    S_R_CHK,
    S_R_TAG,
    S_U_RD,
    S_U_W1,
    S_U_W2,
    S_P_A,
    S_P_B,
    S_CLEAR,
    S_SWEEP,
    S_I_NEXT,
    S_EMIT
  } state_t;

  typedef struct packed {
    op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              ord_big;
    logic              found;
    logic              free_bad;
    logic              bud_ok;
    logic              tag_match;
    logic              split_more;
    logic              sweep_last;
    logic              init_more;
    logic              out_free;
  } dp_stat_t;

endpackage

// ----- rtl/core/bpa_ctrl.sv -----
module bpa_ctrl import bpa_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state_r, state_nxt;
  logic   is_alloc, is_init;

  assign is_alloc  = (stat.func == FN_ALLOC);
  assign is_init   = (stat.func == FN_INIT);
  assign in_tready = (state_r == S_IDLE);

  // state register, reset starts with the tag clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_SWEEP;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:     if (in_tvalid) state_nxt = S_DISPATCH;
      S_DISPATCH: begin
        if (stat.func == FN_ALLOC) begin
          state_nxt = stat.ord_big ? S_BADORD : S_A_FIND;
        end else if (stat.func == FN_FREE) begin
          state_nxt = stat.ord_big ? S_BADORD : S_F_RD;
        end else if (stat.func == FN_INIT) begin
          state_nxt = S_CLEAR;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_BADORD:   state_nxt = S_EMIT;
      S_A_FIND:   state_nxt = stat.found ? S_U_RD : S_EMIT;
      S_A_SPLIT:  state_nxt = stat.split_more ? S_P_A : S_EMIT;
      S_F_RD:     state_nxt = S_F_CHK;
      S_F_CHK:    state_nxt = stat.free_bad ? S_EMIT : S_R_CHK;
      S_R_CHK:    state_nxt = stat.bud_ok ? S_R_TAG : S_P_A;
      S_R_TAG:    state_nxt = stat.tag_match ? S_U_RD : S_P_A;
      S_U_RD:     state_nxt = S_U_W1;
      S_U_W1:     state_nxt = S_U_W2;
      S_U_W2:     state_nxt = is_alloc ? S_A_SPLIT : S_R_CHK;
      S_P_A:      state_nxt = S_P_B;
      S_P_B: begin
        if (is_alloc) begin
          state_nxt = S_A_SPLIT;
        end else begin
          state_nxt = is_init ? S_I_NEXT : S_EMIT;
        end
      end
      S_CLEAR:    state_nxt = S_SWEEP;
      S_SWEEP: begin
        if (stat.sweep_last) state_nxt = is_init ? S_I_NEXT : S_IDLE;
      end
      S_I_NEXT:   state_nxt = stat.init_more ? S_R_CHK : S_EMIT;
      S_EMIT:     if (stat.out_free) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // datapath command
  always_comb begin
    cmd.op = OP_NONE;
    case (state_r)
      S_IDLE:     if (in_tvalid) cmd.op = OP_LOAD;
      S_BADORD:   cmd.op = OP_BAD_ORDER;
      S_A_FIND:   cmd.op = stat.found ? OP_ALLOC_TAKE : OP_NO_BLOCK;
      S_A_SPLIT:  cmd.op = stat.split_more ? OP_DEC_ORD : OP_ALLOC_FIN;
      S_F_RD:     cmd.op = OP_RD_TAG_PG;
      S_F_CHK:    cmd.op = stat.free_bad ? OP_BAD_PAGE : OP_FREE_GO;
      S_R_CHK:    if (stat.bud_ok) cmd.op = OP_RD_TAG_BUD;
      S_U_RD:     cmd.op = OP_RD_LINKS;
      S_U_W1:     cmd.op = OP_UNLINK1;
      S_U_W2:     cmd.op = is_alloc ? OP_UNLINK2 : OP_MERGE;
      S_P_A:      cmd.op = is_alloc ? OP_PUSH_A_SPLIT : OP_PUSH_A_IDX;
      S_P_B:      cmd.op = OP_PUSH_B;
      S_CLEAR:    cmd.op = OP_CLEAR;
      S_SWEEP:    cmd.op = OP_SWEEP;
      S_I_NEXT:   if (stat.init_more) cmd.op = OP_INIT_PAGE;
      S_EMIT:     if (stat.out_free) cmd.op = OP_EMIT;
      default:    cmd.op = OP_NONE;
    endcase
  end

endmodule

// ----- rtl/core/bpa_datapath.sv -----
module bpa_datapath import bpa_pkg::*; #(
  parameter int NUM_PAGES  = NUM_PAGES_DEF,
  parameter int NUM_ORDERS = NUM_ORDERS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  dp_cmd_t             cmd,
  output dp_stat_t            stat,
  input  logic [FUNC_W-1:0]   in_func,
  input  logic [ORDER_W-1:0]  in_order,
  input  logic [PAGE_W-1:0]   in_page,
  input  logic                cfg_we,
  input  logic [CFG_W-1:0]    cfg_wdata,
  input  logic                out_tready,
  output logic                out_valid,
  output logic [STATUS_W-1:0] out_status,
  output logic [PAGE_W-1:0]   out_block,
  output logic [TOTAL_W-1:0]  out_free
);

  localparam int PW = $clog2(NUM_PAGES);
  localparam int LW = $clog2(NUM_PAGES + 1);
  localparam int HW = $clog2(NUM_ORDERS);
  localparam int EFF_RST = (PAGE_COUNT_RST > NUM_PAGES) ? NUM_PAGES : PAGE_COUNT_RST;
  localparam logic [LW-1:0] NIL = LW'(NUM_PAGES);

  // list memories and block tags
  logic [LW-1:0]      next_mem [NUM_PAGES];
  logic [LW-1:0]      prev_mem [NUM_PAGES];
  logic [ORDER_W-1:0] tag_mem  [NUM_PAGES];

  // control state
  logic [LW-1:0]      head_r [NUM_ORDERS];
  logic [TOTAL_W-1:0] total_r;
  logic [PW-1:0]      sw_r;
  logic [LW-1:0]      i_r;
  logic [LW-1:0]      eff_r;
  logic [FUNC_W-1:0]  func_r;
  logic               out_valid_r;

  // working registers
  logic [PAGE_W-1:0]   pg_r;
  logic [ORDER_W-1:0]  ord_r, req_r;
  logic [PW-1:0]       idx_r, u_r, blk_r, s_r;
  logic [LW-1:0]       hp_r;
  logic                pb_en_r;
  logic [STATUS_W-1:0] status_r;
  logic [PAGE_W-1:0]   block_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [PAGE_W-1:0]   out_block_r;
  logic [TOTAL_W-1:0]  out_free_r;
  logic [LW-1:0]       next_q, prev_q;
  logic [ORDER_W-1:0]  tag_q;

  // memory port controls
  logic               tag_we, tag_re, link_re, prev_we, next_we;
  logic [PW-1:0]      tag_wa, tag_ra, prev_wa, next_wa;
  logic [ORDER_W-1:0] tag_wd;
  logic [LW-1:0]      prev_wd, next_wd;

  // derived values
  logic [XW-1:0]      bit_x, bud_x, split_x;
  logic [TOTAL_W-1:0] tot_bit;
  logic [LW-1:0]      head_cur;
  logic               found;
  logic [ORDER_W-1:0] found_o;
  logic               push_ok;
  logic [PW-1:0]      push_pg;
  logic               prev_ok, next_ok;

  assign bit_x    = XW'(1) << ord_r;
  assign bud_x    = XW'(idx_r) ^ bit_x;
  assign split_x  = XW'(blk_r) + bit_x;
  assign tot_bit  = TOTAL_W'(1) << ord_r;
  assign head_cur = head_r[ord_r[HW-1:0]];
  assign prev_ok  = (prev_q < NIL);
  assign next_ok  = (next_q < NIL);

  // lowest non-empty list at or above the requested order
  always_comb begin
    found   = 1'b0;
    found_o = '0;
    for (int k = NUM_ORDERS - 1; k >= 0; k--) begin
      if ((head_r[k] < NIL) && (ORDER_W'(k) >= ord_r)) begin
        found   = 1'b1;
        found_o = ORDER_W'(k);
      end
    end
  end

  // push target and whether it exists
  always_comb begin
    if (cmd.op == OP_PUSH_A_SPLIT) begin
      push_pg = PW'(split_x);
      push_ok = (split_x < XW'(NUM_PAGES));
    end else begin
      push_pg = idx_r;
      push_ok = 1'b1;
    end
  end

  // status to controller
  always_comb begin
    stat.func       = func_r;
    stat.ord_big    = (32'(ord_r) >= NUM_ORDERS);
    stat.found      = found;
    stat.free_bad   = ((XW'(pg_r) & (bit_x - XW'(1))) != '0) ||
                      ((XW'(pg_r) + bit_x) > XW'(eff_r)) ||
                      (XW'(pg_r) >= XW'(NUM_PAGES)) ||
                      (tag_q != TAG_INUSE);
    stat.bud_ok     = ((32'(ord_r) + 1) < NUM_ORDERS) &&
                      (bud_x < XW'(eff_r)) && (bud_x < XW'(NUM_PAGES));
    stat.tag_match  = (tag_q == ord_r);
    stat.split_more = (ord_r > req_r);
    stat.sweep_last = (sw_r == PW'(NUM_PAGES - 1));
    stat.init_more  = (i_r < eff_r);
    stat.out_free   = !out_valid_r || out_tready;
  end

  // memory port selection
  always_comb begin
    tag_we  = 1'b0;
    tag_wa  = sw_r;
    tag_wd  = TAG_INUSE;
    tag_re  = 1'b0;
    tag_ra  = PW'(pg_r);
    link_re = 1'b0;
    prev_we = 1'b0;
    prev_wa = u_r;
    prev_wd = NIL;
    next_we = 1'b0;
    next_wa = u_r;
    next_wd = NIL;
    case (cmd.op)
      OP_SWEEP:      tag_we = 1'b1;
      OP_RD_TAG_PG:  tag_re = 1'b1;
      OP_RD_TAG_BUD: begin
        tag_re = 1'b1;
        tag_ra = PW'(bud_x);
      end
      OP_RD_LINKS:   link_re = 1'b1;
      OP_UNLINK1: begin
        next_we = prev_ok;
        next_wa = PW'(prev_q);
        next_wd = next_q;
        prev_we = next_ok;
        prev_wa = PW'(next_q);
        prev_wd = prev_q;
      end
      OP_UNLINK2: begin
        prev_we = 1'b1;
        next_we = 1'b1;
      end
      OP_MERGE: begin
        prev_we = 1'b1;
        next_we = 1'b1;
        tag_we  = 1'b1;
        tag_wa  = u_r;
      end
      OP_ALLOC_FIN: begin
        tag_we = 1'b1;
        tag_wa = blk_r;
      end
      OP_PUSH_A_IDX, OP_PUSH_A_SPLIT: begin
        tag_we  = push_ok;
        tag_wa  = push_pg;
        tag_wd  = ord_r;
        prev_we = push_ok;
        prev_wa = push_pg;
        next_we = push_ok;
        next_wa = push_pg;
        next_wd = head_cur;
      end
      OP_PUSH_B: begin
        prev_we = pb_en_r;
        prev_wa = PW'(hp_r);
        prev_wd = LW'(s_r);
      end
      default: ;
    endcase
  end

  // memories
  always_ff @(posedge clk) begin
    if (tag_we) tag_mem[tag_wa] <= tag_wd;
    if (tag_re) tag_q <= tag_mem[tag_ra];
  end

  always_ff @(posedge clk) begin
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    if (link_re) prev_q <= prev_mem[u_r];
  end

  always_ff @(posedge clk) begin
    if (next_we) next_mem[next_wa] <= next_wd;
    if (link_re) next_q <= next_mem[u_r];
  end

  // list heads, free total, counters and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_ORDERS; k++) head_r[k] <= NIL;
      total_r     <= '0;
      sw_r        <= '0;
      i_r         <= '0;
      eff_r       <= LW'(EFF_RST);
      func_r      <= FN_ALLOC;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        eff_r <= (32'(cfg_wdata) > NUM_PAGES) ? NIL : LW'(cfg_wdata);
      end
      if (cmd.op == OP_EMIT) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (cmd.op)
        OP_LOAD:  func_r <= in_func;
        OP_CLEAR: begin
          for (int k = 0; k < NUM_ORDERS; k++) head_r[k] <= NIL;
          total_r <= '0;
          sw_r    <= '0;
          i_r     <= '0;
        end
        OP_SWEEP: sw_r <= stat.sweep_last ? '0 : sw_r + PW'(1);
        OP_INIT_PAGE: i_r <= i_r + LW'(1);
        OP_UNLINK1: begin
          if (!prev_ok) head_r[ord_r[HW-1:0]] <= next_q;
          total_r <= total_r - tot_bit;
        end
        OP_PUSH_A_IDX, OP_PUSH_A_SPLIT: begin
          if (push_ok) begin
            head_r[ord_r[HW-1:0]] <= LW'(push_pg);
            total_r <= total_r + tot_bit;
          end
        end
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        pg_r     <= in_page;
        ord_r    <= in_order;
        req_r    <= in_order;
        status_r <= STS_OK;
        block_r  <= '0;
      end
      OP_BAD_ORDER: status_r <= STS_BAD_ORDER;
      OP_NO_BLOCK:  status_r <= STS_NO_BLOCK;
      OP_BAD_PAGE:  status_r <= STS_BAD_PAGE;
      OP_ALLOC_TAKE: begin
        ord_r <= found_o;
        u_r   <= PW'(head_r[found_o[HW-1:0]]);
        blk_r <= PW'(head_r[found_o[HW-1:0]]);
      end
      OP_FREE_GO:    idx_r <= PW'(pg_r);
      OP_RD_TAG_BUD: u_r <= PW'(bud_x);
      OP_MERGE: begin
        idx_r <= idx_r & ~PW'(bit_x);
        ord_r <= ord_r + ORDER_W'(1);
      end
      OP_DEC_ORD:   ord_r <= ord_r - ORDER_W'(1);
      OP_ALLOC_FIN: block_r <= PAGE_W'(blk_r);
      OP_PUSH_A_IDX, OP_PUSH_A_SPLIT: begin
        s_r     <= push_pg;
        hp_r    <= head_cur;
        pb_en_r <= push_ok && (head_cur < NIL);
      end
      OP_INIT_PAGE: begin
        idx_r <= PW'(i_r);
        ord_r <= '0;
      end
      OP_EMIT: begin
        out_status_r <= status_r;
        out_block_r  <= block_r;
        out_free_r   <= total_r;
      end
      default: ;
    endcase
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_block  = out_block_r;
  assign out_free   = out_free_r;

  // a result is only loaded when the output register can take it
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_EMIT) |-> (!out_valid_r || out_tready))
    else $error("result loaded over a pending beat");

  // tag memory never reads and writes in the same cycle
  a_tag_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(tag_we && tag_re))
    else $error("tag memory read and write collide");

  // unlink writes use link data fetched the cycle before
  a_unlink_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_UNLINK1) |-> ($past(cmd.op) == OP_RD_LINKS))
    else $error("unlink without fresh link read");

  // a finished allocation always reports success
  a_alloc_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_ALLOC_FIN) |=> (status_r == STS_OK))
    else $error("allocation finished with error status");

endmodule

// ----- rtl/core/buddy_page_allocator.sv -----
// Buddy page allocator. Each input beat is one request (allocate, free or
// initialize) and yields exactly one result beat with a status, the first page
// of an allocated block and the free page total. Requests are handled one at a
// time by a sequencer over three single-port page memories (next link, previous
// link, block tag), one access per memory per cycle. An allocate splits the
// found block once per level down to the requested order; a free merges with
// its buddy for as long as the buddy is free. Initialize first clears all
// NUM_PAGES tags, one per cycle, then frees every managed page at order 0,
// merging buddies as it goes. After reset the same tag clearing pass runs over
// all NUM_PAGES tags (4096 by default) before the first request is taken. The
// page count register may be written only while idle.
module buddy_page_allocator import bpa_pkg::*; #(
  parameter int NUM_PAGES  = NUM_PAGES_DEF,
  parameter int NUM_ORDERS = NUM_ORDERS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  // request beat
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // func[1:0], order[5:2], page_index[17:6]
  // result beat
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata,  // status[1:0], block_page[13:2], free_total[26:14]
  // page count register
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data
);

  dp_cmd_t             cmd;
  dp_stat_t            stat;
  logic [STATUS_W-1:0] out_status;
  logic [PAGE_W-1:0]   out_block;
  logic [TOTAL_W-1:0]  out_free;

  assign cfg_ready = 1'b1;
  assign out_tdata = {(OUT_W - STATUS_W - PAGE_W - TOTAL_W)'(0), out_free, out_block,
                      out_status};

  // sequencer
  bpa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // lists, tags and result register
  bpa_datapath #(
    .NUM_PAGES  (NUM_PAGES),
    .NUM_ORDERS (NUM_ORDERS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_func    (in_tdata[1:0]),
    .in_order   (in_tdata[5:2]),
    .in_page    (in_tdata[17:6]),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_wdata  (cfg_data),
    .out_tready (out_tready),
    .out_valid  (out_tvalid),
    .out_status (out_status),
    .out_block  (out_block),
    .out_free   (out_free)
  );

endmodule
